@@ src/gob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gob_pkg;

	// widths fixed by the register and request fields
	localparam int unsigned COORD_W = 7;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned AREA_W  = 7;
	localparam int unsigned APB_DW  = 32;
	localparam int unsigned APB_AW  = 3;

	localparam logic [AREA_W-1:0] AREA_RESET = 7'd64;

	// request opcodes
	typedef enum logic [1:0] {
		OP_MARK_USED = 2'd0,
		OP_MARK_FREE = 2'd1,
		OP_MARK_RECT = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	// register indexes, decoded from paddr[2]
	typedef enum logic {
		REG_AREA_WIDTH  = 1'b0,
		REG_AREA_HEIGHT = 1'b1
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BASE,
		ST_RD,
		ST_WR
	} state_t;

	// effective area, already saturated to the grid size
	typedef struct packed {
		logic [AREA_W-1:0] width;
		logic [AREA_W-1:0] height;
	} area_t;

endpackage

`default_nettype wire

@@ src/gob_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gob_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/gob_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gob_cfg #(
	parameter int unsigned MAX_COLUMNS = 64,
	parameter int unsigned MAX_ROWS    = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gob_pkg::APB_AW-1:0] paddr,
	input  logic [gob_pkg::APB_DW-1:0] pwdata,
	output logic [gob_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output gob_pkg::area_t             area
);

	logic [gob_pkg::AREA_W-1:0] area_width_q;
	logic [gob_pkg::AREA_W-1:0] area_height_q;
	logic                       wr_en;
	gob_pkg::reg_idx_t          reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = gob_pkg::reg_idx_t'(paddr[2]);

	// register writes on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q  <= gob_pkg::AREA_RESET;
			area_height_q <= gob_pkg::AREA_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				gob_pkg::REG_AREA_WIDTH:  area_width_q  <= pwdata[gob_pkg::AREA_W-1:0];
				gob_pkg::REG_AREA_HEIGHT: area_height_q <= pwdata[gob_pkg::AREA_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			gob_pkg::REG_AREA_WIDTH:  prdata = gob_pkg::APB_DW'(area_width_q);
			gob_pkg::REG_AREA_HEIGHT: prdata = gob_pkg::APB_DW'(area_height_q);
		endcase
	end

	// saturate to the grid size
	always_comb begin
		area.width  = (9'(area_width_q) > 9'(MAX_COLUMNS)) ?
			gob_pkg::AREA_W'(MAX_COLUMNS) : area_width_q;
		area.height = (9'(area_height_q) > 9'(MAX_ROWS)) ?
			gob_pkg::AREA_W'(MAX_ROWS) : area_height_q;
	end

endmodule

`default_nettype wire

@@ src/gob_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gob_seq #(
	parameter int unsigned MAX_COLUMNS = 64,
	parameter int unsigned MAX_ROWS    = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gob_pkg::area_t              area,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  opcode,
	input  logic signed [gob_pkg::POS_W-1:0] cell_x,
	input  logic signed [gob_pkg::POS_W-1:0] cell_y,
	input  logic [gob_pkg::COORD_W-1:0] rect_width,
	input  logic [gob_pkg::COORD_W-1:0] rect_height,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        cell_free
);

	localparam int unsigned IDX_W = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int unsigned DEPTH = (MAX_COLUMNS * MAX_ROWS + 7) / 8;
	localparam int unsigned AW    = IDX_W - 3;
	localparam int unsigned CW    = gob_pkg::COORD_W;

	typedef struct packed {
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
		logic          empty;
	} clip_t;

	// clip the span hi-len+1 .. hi to 0 .. lim-1
	function automatic clip_t clip_span(logic signed [gob_pkg::POS_W-1:0] hi,
			logic [CW-1:0] len, logic [CW-1:0] lim);
		logic signed [9:0] h;
		logic signed [9:0] l;
		logic signed [9:0] m;
		logic signed [9:0] clo;
		logic signed [9:0] chi;
		clip_t             r;
		h   = 10'(hi);
		l   = h - $signed({3'b000, len}) + 10'sd1;
		m   = $signed({3'b000, lim}) - 10'sd1;
		clo = (l < 10'sd0) ? 10'sd0 : l;
		chi = (h > m) ? m : h;
		r.empty = chi < clo;
		r.lo    = clo[CW-1:0];
		r.hi    = chi[CW-1:0];
		return r;
	endfunction

	gob_pkg::state_t state_q, state_d;
	gob_pkg::op_t    op_q;
	logic [CW-1:0]   xlo_q, xhi_q, yrow_q, yhi_q;
	logic            empty_q;
	logic [IDX_W-1:0] base_q;
	logic [AW-1:0]   byte_q;
	logic            first_q;
	logic [AW-1:0]   byte_s1;
	logic [AW-1:0]   clr_q;
	logic            rsp_valid_q;
	logic            free_q;

	logic            is_rect;
	logic [CW-1:0]   span_w, span_h;
	clip_t           cx, cy;
	gob_pkg::state_t start_state;
	logic [CW-1:0]   mult_a;
	logic [13:0]     prod;
	logic [IDX_W-1:0] s_idx, e_idx;
	logic [AW-1:0]   sb, eb;
	logic            row_last, all_last, slot_free;
	logic [2:0]      lo_bit, hi_bit;
	logic [7:0]      mask, new_byte;
	logic            accept, finish, row_step, byte_step, base_load;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	// request decode and clipping, a single cell is a one by one span
	assign is_rect = (opcode == gob_pkg::OP_MARK_RECT);
	assign span_w  = is_rect ? rect_width : CW'(1);
	assign span_h  = is_rect ? rect_height : CW'(1);
	assign cx      = clip_span(cell_x, span_w, area.width);
	assign cy      = clip_span(cell_y, span_h, area.height);
	assign start_state = (is_rect && !(cx.empty || cy.empty)) ?
		gob_pkg::ST_BASE : gob_pkg::ST_RD;

	// shared row base multiplier
	assign mult_a = (state_q == gob_pkg::ST_BASE) ? yrow_q : cell_y[CW-1:0];
	assign prod   = 14'(mult_a) * 14'(area.width);

	// linear span of the current row and its byte range
	assign s_idx = base_q + IDX_W'(xlo_q);
	assign e_idx = base_q + IDX_W'(xhi_q);
	assign sb    = s_idx[IDX_W-1:3];
	assign eb    = e_idx[IDX_W-1:3];

	assign row_last  = (byte_s1 == eb);
	assign all_last  = empty_q || (row_last && (yrow_q == yhi_q));
	assign slot_free = !rsp_valid_q || rsp_ready;

	// bits of the current byte inside the span
	always_comb begin
		lo_bit = (byte_s1 == sb) ? s_idx[2:0] : 3'd0;
		hi_bit = (byte_s1 == eb) ? e_idx[2:0] : 3'd7;
		mask   = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
		new_byte = (op_q == gob_pkg::OP_MARK_FREE) ? (ram_rdata & ~mask) :
			(ram_rdata | mask);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gob_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		finish    = 1'b0;
		row_step  = 1'b0;
		byte_step = 1'b0;
		base_load = 1'b0;
		unique case (state_q)
			gob_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = gob_pkg::ST_IDLE;
				end
			end
			gob_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = start_state;
				end
			end
			gob_pkg::ST_BASE: begin
				base_load = 1'b1;
				state_d   = gob_pkg::ST_RD;
			end
			gob_pkg::ST_RD: begin
				ram_re  = !empty_q;
				state_d = gob_pkg::ST_WR;
			end
			gob_pkg::ST_WR: begin
				if (!all_last) begin
					ram_we  = (op_q != gob_pkg::OP_QUERY);
					state_d = gob_pkg::ST_RD;
					if (row_last) begin
						row_step = 1'b1;
					end else begin
						byte_step = 1'b1;
					end
				end else if (slot_free) begin
					ram_we    = !empty_q && (op_q != gob_pkg::OP_QUERY);
					finish    = 1'b1;
					req_ready = 1'b1;
					state_d   = req_valid ? start_state : gob_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gob_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid & req_ready;

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == gob_pkg::ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= gob_pkg::op_t'(opcode);
			xlo_q   <= cx.lo;
			xhi_q   <= cx.hi;
			yrow_q  <= cy.lo;
			yhi_q   <= cy.hi;
			empty_q <= cx.empty | cy.empty;
			base_q  <= IDX_W'(prod);
			first_q <= 1'b1;
		end else if (base_load) begin
			base_q <= IDX_W'(prod);
		end else if (row_step) begin
			yrow_q  <= yrow_q + CW'(1);
			base_q  <= base_q + IDX_W'(area.width);
			first_q <= 1'b1;
		end else if (byte_step) begin
			byte_q  <= byte_s1 + AW'(1);
			first_q <= 1'b0;
		end
		if (state_q == gob_pkg::ST_RD) begin
			byte_s1 <= ram_raddr;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			free_q <= (op_q == gob_pkg::OP_QUERY) && !empty_q && !ram_rdata[s_idx[2:0]];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign cell_free = free_q;

	// occupancy store
	assign ram_raddr = first_q ? sb : byte_q;
	assign ram_waddr = (state_q == gob_pkg::ST_CLEAR) ? clr_q : byte_s1;
	assign ram_wdata = (state_q == gob_pkg::ST_CLEAR) ? 8'h00 : new_byte;

	gob_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// no request is taken during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gob_pkg::ST_CLEAR |-> !req_ready)
		else $error("request taken while store is being cleared");

	// a write-back always follows a read of the same walk
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gob_pkg::ST_WR |->
			($past(state_q) == gob_pkg::ST_RD || $past(state_q) == gob_pkg::ST_WR))
		else $error("write-back without a preceding read");

	// the byte walk never passes the end of the row span
	a_walk_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gob_pkg::ST_WR && !empty_q) |-> byte_s1 <= eb)
		else $error("byte walk ran past the row span");

	// only queries can report a free cell
	a_free_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && op_q != gob_pkg::OP_QUERY) |=> !free_q)
		else $error("free flag set for a mark request");

endmodule

`default_nettype wire

@@ src/grid_occupancy_bitmap_core.sv @@
// Single-cell mark or query: one read-modify-write of the byte store, then the
// result register; a new request is taken only as the previous one finishes.
// Rectangle mark: a row base step, then one read-modify-write per byte touched
// in each clipped row; a rectangle that clips to nothing leaves the store as is.
// After reset the byte store, (MAX_COLUMNS*MAX_ROWS+7)/8 bytes (512 at default
// size), is cleared one byte a cycle with req_ready low; area registers reset to 64.
`timescale 1ns / 1ps
`default_nettype none

module grid_occupancy_bitmap_core #(
	parameter int unsigned MAX_COLUMNS = 64,
	parameter int unsigned MAX_ROWS    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gob_pkg::APB_AW-1:0]        paddr,
	input  logic [gob_pkg::APB_DW-1:0]        pwdata,
	output logic [gob_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        opcode,
	input  logic signed [gob_pkg::POS_W-1:0]  cell_x,
	input  logic signed [gob_pkg::POS_W-1:0]  cell_y,
	input  logic [gob_pkg::COORD_W-1:0]       rect_width,
	input  logic [gob_pkg::COORD_W-1:0]       rect_height,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              cell_free
);

	gob_pkg::area_t area;

	// area registers
	gob_cfg #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.area   (area)
	);

	// request sequencer and byte store
	gob_seq #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.area       (area),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cell_free  (cell_free)
	);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int GRID_COLS = 64;
	localparam int GRID_ROWS = 64;
	localparam int PHASES    = 10;
	localparam int PER_PHASE = 140;

	// one request as presented on the request channel
	typedef struct {
		gob_pkg::op_t       op;
		logic signed [7:0]  x;
		logic signed [7:0]  y;
		logic [6:0]         w;
		logic [6:0]         h;
	} grid_req_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [gob_pkg::APB_AW-1:0]   paddr = '0;
	logic [gob_pkg::APB_DW-1:0]   pwdata = '0;
	logic [gob_pkg::APB_DW-1:0]   prdata;
	logic                         pready;
	logic                         req_valid = 1'b0;
	logic                         req_ready;
	gob_pkg::op_t                 opcode = gob_pkg::OP_MARK_USED;
	logic signed [7:0]            cell_x = '0;
	logic signed [7:0]            cell_y = '0;
	logic [6:0]                   rect_width = '0;
	logic [6:0]                   rect_height = '0;
	logic                         rsp_valid;
	logic                         rsp_ready = 1'b0;
	logic                         cell_free;

	// area settings of the random phases
	int phase_w [PHASES] = '{1, 0, 127, 64, 13, 8, 64, 65, 5, 64};
	int phase_h [PHASES] = '{1, 64, 127, 0, 7, 64, 1, 3, 5, 64};

	// mirror of the block: area registers and one bit per cell
	logic [6:0]  area_w = gob_pkg::AREA_RESET;
	logic [6:0]  area_h = gob_pkg::AREA_RESET;
	logic        occupied [GRID_COLS*GRID_ROWS];

	grid_req_t   pending [$];
	logic        free_expect [$];

	int errors = 0;
	int send_wait = 0;
	int send_calm = 0;
	int recv_wait = 0;
	int recv_calm = 0;
	int n_ops [4] = '{0, 0, 0, 0};
	int n_free = 0;
	int n_phases = 0;

	grid_occupancy_bitmap_core #(
		.MAX_COLUMNS(GRID_COLS),
		.MAX_ROWS   (GRID_ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cell_free  (cell_free)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic int eff_cols();
		return (area_w > GRID_COLS) ? GRID_COLS : int'(area_w);
	endfunction

	function automatic int eff_rows();
		return (area_h > GRID_ROWS) ? GRID_ROWS : int'(area_h);
	endfunction

	function automatic bit in_area(int x, int y);
		return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
	endfunction

	// update the cell mirror for one request and return the expected cell_free
	function automatic logic apply_request(grid_req_t r);
		int xi, yi, x_lo, y_lo, x_hi, y_hi, i, j;
		logic ans;
		xi = r.x;
		yi = r.y;
		ans = 1'b0;
		case (r.op)
			gob_pkg::OP_MARK_USED: begin
				if (in_area(xi, yi))
					occupied[yi * eff_cols() + xi] = 1'b1;
			end
			gob_pkg::OP_MARK_FREE: begin
				if (in_area(xi, yi))
					occupied[yi * eff_cols() + xi] = 1'b0;
			end
			gob_pkg::OP_MARK_RECT: begin
				x_lo = xi - int'(r.w) + 1;
				y_lo = yi - int'(r.h) + 1;
				x_hi = xi;
				y_hi = yi;
				if (x_lo < 0) x_lo = 0;
				if (y_lo < 0) y_lo = 0;
				if (x_hi > eff_cols() - 1) x_hi = eff_cols() - 1;
				if (y_hi > eff_rows() - 1) y_hi = eff_rows() - 1;
				for (i = x_lo; i <= x_hi; i++)
					for (j = y_lo; j <= y_hi; j++)
						occupied[j * eff_cols() + i] = 1'b1;
			end
			default: begin
				if (in_area(xi, yi))
					ans = !occupied[yi * eff_cols() + xi];
			end
		endcase
		return ans;
	endfunction

	// idle cycles before the next transfer, with runs of back-to-back traffic
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 9);
	endfunction

	function automatic void add_item(gob_pkg::op_t op, int x, int y, int w, int h);
		grid_req_t r;
		r.op = op;
		r.x = x[7:0];
		r.y = y[7:0];
		r.w = w[6:0];
		r.h = h[6:0];
		pending.push_back(r);
	endfunction

	function automatic int pick_coord(int lim);
		if ($urandom_range(0, 99) < 12)
			return $signed(8'($urandom()));
		return int'($urandom_range(0, lim + 1)) - 1;
	endfunction

	function automatic int pick_size();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 127);
		return $urandom_range(0, 6);
	endfunction

	// register write: setup cycle, then access cycle until pready
	task automatic write_area(gob_pkg::reg_idx_t idx, logic [6:0] val);
		logic [31:0] word;
		word = $urandom();
		word[6:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == gob_pkg::REG_AREA_WIDTH)
			area_w = val;
		else
			area_h = val;
	endtask

	// wait until every request is sent and every result has come back
	task automatic drain();
		while (pending.size() != 0 || req_valid || free_expect.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// request driver: presents queued requests, predicts on each transfer
	always @(posedge clk) begin : req_driver
		logic load;
		grid_req_t cur;
		grid_req_t nxt;
		load = 1'b0;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				cur.op = opcode;
				cur.x = cell_x;
				cur.y = cell_y;
				cur.w = rect_width;
				cur.h = rect_height;
				free_expect.push_back(apply_request(cur));
				n_ops[opcode]++;
				send_wait = draw_gap(send_calm);
				load = (send_wait == 0) && (pending.size() != 0);
			end else if (!req_valid) begin
				if (send_wait > 0)
					send_wait--;
				else if (pending.size() != 0)
					load = 1'b1;
			end
			if (load) begin
				nxt = pending.pop_front();
				opcode <= nxt.op;
				cell_x <= nxt.x;
				cell_y <= nxt.y;
				rect_width <= nxt.w;
				rect_height <= nxt.h;
				req_valid <= 1'b1;
			end else if (req_valid && req_ready) begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor: random backpressure, compare against oldest prediction
	always @(posedge clk) begin : rsp_monitor
		logic want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (free_expect.size() == 0) begin
					$error("unexpected result transfer: cell_free actual %0b", cell_free);
					errors++;
				end else begin
					want = free_expect.pop_front();
					if (cell_free !== want) begin
						$error("cell_free: expected %0b, actual %0b", want, cell_free);
						errors++;
					end
					if (want)
						n_free++;
				end
				recv_wait = draw_gap(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			rsp_ready <= (recv_wait == 0);
		end
	end

	initial begin : stimulus
		int p, k, r, lx, ly;
		gob_pkg::op_t op;
		for (k = 0; k < GRID_COLS * GRID_ROWS; k++)
			occupied[k] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset area of 64 by 64
		@(negedge clk);
		add_item(gob_pkg::OP_QUERY, 0, 0, 0, 0);
		add_item(gob_pkg::OP_MARK_USED, 0, 0, 0, 0);
		add_item(gob_pkg::OP_QUERY, 0, 0, 0, 0);
		add_item(gob_pkg::OP_MARK_USED, 63, 63, 0, 0);
		add_item(gob_pkg::OP_QUERY, 63, 63, 0, 0);
		add_item(gob_pkg::OP_QUERY, 62, 63, 0, 0);
		// queries outside the area, both sides and the field extremes
		add_item(gob_pkg::OP_QUERY, 64, 0, 0, 0);
		add_item(gob_pkg::OP_QUERY, 0, 64, 0, 0);
		add_item(gob_pkg::OP_QUERY, -1, 0, 0, 0);
		add_item(gob_pkg::OP_QUERY, -128, -128, 0, 0);
		add_item(gob_pkg::OP_QUERY, 127, 127, 0, 0);
		// out-of-area marks that would alias onto an in-area index
		add_item(gob_pkg::OP_MARK_USED, 64, 3, 0, 0);
		add_item(gob_pkg::OP_QUERY, 0, 4, 0, 0);
		add_item(gob_pkg::OP_MARK_USED, -1, 5, 0, 0);
		add_item(gob_pkg::OP_QUERY, 63, 4, 0, 0);
		add_item(gob_pkg::OP_MARK_FREE, 0, 0, 0, 0);
		add_item(gob_pkg::OP_QUERY, 0, 0, 0, 0);
		// rectangles: plain, zero width, clipped to nothing, oversized
		add_item(gob_pkg::OP_MARK_RECT, 10, 10, 4, 3);
		add_item(gob_pkg::OP_QUERY, 7, 8, 0, 0);
		add_item(gob_pkg::OP_QUERY, 6, 8, 0, 0);
		add_item(gob_pkg::OP_MARK_RECT, 20, 20, 0, 5);
		add_item(gob_pkg::OP_QUERY, 20, 20, 0, 0);
		add_item(gob_pkg::OP_MARK_RECT, -1, 5, 10, 10);
		add_item(gob_pkg::OP_MARK_RECT, 127, 127, 127, 127);
		add_item(gob_pkg::OP_QUERY, 0, 30, 0, 0);
		add_item(gob_pkg::OP_MARK_RECT, 63, 63, 64, 64);
		add_item(gob_pkg::OP_MARK_FREE, 30, 30, 0, 0);
		add_item(gob_pkg::OP_QUERY, 30, 30, 0, 0);
		drain();
		n_phases = 1;

		// random phases, each under its own area setting
		for (p = 0; p < PHASES; p++) begin
			write_area(gob_pkg::REG_AREA_WIDTH, phase_w[p][6:0]);
			write_area(gob_pkg::REG_AREA_HEIGHT, phase_h[p][6:0]);
			@(negedge clk);
			lx = eff_cols();
			ly = eff_rows();
			for (k = 0; k < PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					op = gob_pkg::OP_MARK_USED;
				else if (r < 55)
					op = gob_pkg::OP_MARK_FREE;
				else if (r < 65)
					op = gob_pkg::OP_MARK_RECT;
				else
					op = gob_pkg::OP_QUERY;
				add_item(op, pick_coord(lx), pick_coord(ly), pick_size(), pick_size());
			end
			drain();
			n_phases++;
		end

		repeat (20) @(posedge clk);
		$display("covered %0d area settings: %0d cell marks, %0d frees, %0d rectangles",
			n_phases, n_ops[gob_pkg::OP_MARK_USED], n_ops[gob_pkg::OP_MARK_FREE],
			n_ops[gob_pkg::OP_MARK_RECT]);
		$display("and %0d queries, %0d of them answered free",
			n_ops[gob_pkg::OP_QUERY], n_free);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
